/* hdl/mbq_pkg.sv */
// Shared types, widths and register constants for the multichannel biquad low-pass filter.
package mbq_pkg;

  // Channel history depth and field widths.
  localparam int NUM_CHANNELS = 8;
  localparam int CHAN_W       = 3;
  localparam int SAMPLE_W     = 16;
  localparam int OUT_W        = 32;
  localparam int COEFF_W      = 32;
  localparam int CHAN_AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Stream word widths, padded to whole bytes.
  localparam int S_TDATA_W = ((CHAN_W + SAMPLE_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((CHAN_W + OUT_W + 7) / 8) * 8;

  // Fixed-point scaling: feedback products drop 16 bits, the sum drops 14 with rounding.
  localparam int FB_SHIFT  = 16;
  localparam int OUT_SHIFT = 14;

  // Result queue; the depth must be a power of two so the pointers wrap on their own.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_COEFF_ZERO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_COEFF_ONE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEED_COEFF_TWO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COEFF_ONE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COEFF_TWO  = 3'd4;

  // Reset coefficients (Q2.30): 12 Hz Butterworth low-pass.
  localparam logic signed [COEFF_W-1:0] RST_FEED_COEFF_ZERO = 32'sd1014355;
  localparam logic signed [COEFF_W-1:0] RST_FEED_COEFF_ONE  = 32'sd2028710;
  localparam logic signed [COEFF_W-1:0] RST_FEED_COEFF_TWO  = 32'sd1014355;
  localparam logic signed [COEFF_W-1:0] RST_BACK_COEFF_ONE  = -32'sd2052132225;
  localparam logic signed [COEFF_W-1:0] RST_BACK_COEFF_TWO  = 32'sd982447822;

  // Coefficient set as held in the configuration registers.
  typedef struct packed {
    logic signed [COEFF_W-1:0] b0;
    logic signed [COEFF_W-1:0] b1;
    logic signed [COEFF_W-1:0] b2;
    logic signed [COEFF_W-1:0] a1;
    logic signed [COEFF_W-1:0] a2;
  } coeff_t;

  // One channel's history entry.
  typedef struct packed {
    logic signed [OUT_W-1:0]    y2;
    logic signed [OUT_W-1:0]    y1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] x1;
  } hist_t;

  // Control tag that follows a word down the pipeline.
  typedef struct packed {
    logic              valid;
    logic              in_range;
    logic [CHAN_W-1:0] chan;
  } tag_t;

  // Result word as queued; chan sits in the low bits.
  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic [CHAN_W-1:0]       chan;
  } result_t;

endpackage

/* hdl/mbq_mac.sv */
// Multiply and accumulate pipeline of the biquad: products, partial sums, rounding, saturation.
module mbq_mac (
  input  logic                                 clk,
  input  logic signed [mbq_pkg::SAMPLE_W-1:0]  x,
  input  mbq_pkg::hist_t                       hist,
  input  mbq_pkg::coeff_t                      coeff,
  output logic signed [mbq_pkg::OUT_W-1:0]     y
);
  import mbq_pkg::*;

  // Widths of the exact intermediate values.
  localparam int FF_W   = COEFF_W + SAMPLE_W;        // b*x product
  localparam int FBP_W  = COEFF_W + OUT_W;           // a*y product
  localparam int FB_W   = FBP_W - FB_SHIFT;          // a*y after the shift
  localparam int FFS_W  = FF_W + 2;                  // sum of three feedforward terms
  localparam int FBS_W  = FB_W + 1;                  // sum of two feedback terms
  localparam int ACC_W  = ((FFS_W > FBS_W) ? FFS_W : FBS_W) + 1;
  localparam int RND_W  = ACC_W + 1;
  localparam int SHR_W  = RND_W - OUT_SHIFT;
  localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic signed [FF_W-1:0]  p_b0;
  logic signed [FF_W-1:0]  p_b1;
  logic signed [FF_W-1:0]  p_b2;
  logic signed [FB_W-1:0]  p_a1;
  logic signed [FB_W-1:0]  p_a2;
  logic signed [FBP_W-1:0] full_a1;
  logic signed [FBP_W-1:0] full_a2;
  logic signed [FFS_W-1:0] ff_sum;
  logic signed [FBS_W-1:0] fb_sum;
  logic signed [ACC_W-1:0] acc;
  logic signed [RND_W-1:0] rnd;
  logic signed [SHR_W-1:0] shr;
  logic                    fits;

  assign full_a1 = FBP_W'(coeff.a1) * FBP_W'(hist.y1);
  assign full_a2 = FBP_W'(coeff.a2) * FBP_W'(hist.y2);

  // Stage one: five products; the feedback ones are floored to Q.30 here.
  always_ff @(posedge clk) begin
    p_b0 <= FF_W'(coeff.b0) * FF_W'(x);
    p_b1 <= FF_W'(coeff.b1) * FF_W'(hist.x1);
    p_b2 <= FF_W'(coeff.b2) * FF_W'(hist.x2);
    p_a1 <= full_a1[FBP_W-1:FB_SHIFT];
    p_a2 <= full_a2[FBP_W-1:FB_SHIFT];
  end

  // Stage two: feedforward and feedback sums kept apart.
  always_ff @(posedge clk) begin
    ff_sum <= FFS_W'(p_b0) + FFS_W'(p_b1) + FFS_W'(p_b2);
    fb_sum <= FBS_W'(p_a1) + FBS_W'(p_a2);
  end

  // Final difference, round half up, and saturate to the output width.
  always_comb begin
    acc  = ACC_W'(ff_sum) - ACC_W'(fb_sum);
    rnd  = RND_W'(acc) + ROUND_HALF;
    shr  = rnd[RND_W-1:OUT_SHIFT];
    fits = (shr[SHR_W-1:OUT_W-1] == '0) || (shr[SHR_W-1:OUT_W-1] == '1);
    if (fits) begin
      y = shr[OUT_W-1:0];
    end else if (shr[SHR_W-1]) begin
      y = OUT_MIN;
    end else begin
      y = OUT_MAX;
    end
  end

endmodule

/* hdl/multichannel_biquad_lowpass.sv */
// Top level of the multichannel direct form I biquad low-pass filter.
// A word accepted on the input passes through stages s1, s2 and s3 and is then written into the result queue.
// Throughput: one word per cycle while the receiver keeps up; a word whose channel still has
// a word in the three pipeline stages waits for that word's history write-back, so one
// channel alone cannot take a new word before its last one has left stage s3.
// Reset (synchronous, rst high): default coefficients, zero histories, empty result queue.
module multichannel_biquad_lowpass (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mbq_pkg::S_TDATA_W-1:0]       s_tdata,   // [2:0] chan, [18:3] sample_in, zeros above
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mbq_pkg::M_TDATA_W-1:0]       m_tdata,   // [2:0] chan_out, [34:3] filtered_out, zeros above
  input  logic                                cfg_wen,
  input  logic [mbq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mbq_pkg::COEFF_W-1:0]         cfg_wdata
);
  import mbq_pkg::*;

  localparam int OCC_W = FIFO_AW + 2;

  coeff_t                     coeff;
  logic [CHAN_W-1:0]          in_chan;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_range;
  logic [CHAN_AW-1:0]         in_addr;
  logic                       hazard;
  logic                       accept;

  // Channel history store and the flags that say which entries hold written data.
  hist_t                      hist_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]    hist_valid;
  hist_t                      rd_data;
  logic                       rd_valid;
  hist_t                      s1_hist;

  tag_t                       s1_tag;
  tag_t                       s2_tag;
  tag_t                       s3_tag;
  logic signed [SAMPLE_W-1:0] s1_x;
  logic signed [SAMPLE_W-1:0] s2_x;
  logic signed [SAMPLE_W-1:0] s3_x;
  logic signed [SAMPLE_W-1:0] s2_x1;
  logic signed [SAMPLE_W-1:0] s3_x1;
  logic signed [OUT_W-1:0]    s2_y1;
  logic signed [OUT_W-1:0]    s3_y1;
  logic signed [OUT_W-1:0]    y_sat;
  logic [CHAN_AW-1:0]         s3_addr;
  logic                       wb_en;
  result_t                    res;

  // Result queue.
  result_t                    fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]         wr_ptr;
  logic [FIFO_AW-1:0]         rd_ptr;
  logic [FIFO_AW:0]           fifo_count;
  logic                       push;
  logic                       pop;
  logic [OCC_W-1:0]           occupancy;

  // ---------------------------------------------------------------------------
  // Coefficient registers. Writes to an index past the last register are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff.b0 <= RST_FEED_COEFF_ZERO;
      coeff.b1 <= RST_FEED_COEFF_ONE;
      coeff.b2 <= RST_FEED_COEFF_TWO;
      coeff.a1 <= RST_BACK_COEFF_ONE;
      coeff.a2 <= RST_BACK_COEFF_TWO;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_FEED_COEFF_ZERO: coeff.b0 <= cfg_wdata;
        REG_FEED_COEFF_ONE:  coeff.b1 <= cfg_wdata;
        REG_FEED_COEFF_TWO:  coeff.b2 <= cfg_wdata;
        REG_BACK_COEFF_ONE:  coeff.a1 <= cfg_wdata;
        REG_BACK_COEFF_TWO:  coeff.a2 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. A word is held off when its channel still has a word in flight,
  // because that word's history update has not reached the store yet, or when
  // the queue could not take this word on top of every word already in the pipeline.
  // ---------------------------------------------------------------------------
  assign in_chan   = s_tdata[CHAN_W-1:0];
  assign in_sample = s_tdata[CHAN_W +: SAMPLE_W];
  assign in_range  = int'(in_chan) < NUM_CHANNELS;
  assign in_addr   = CHAN_AW'(in_chan);

  assign hazard = in_range &&
                  ((s1_tag.valid && s1_tag.in_range && (s1_tag.chan == in_chan)) ||
                   (s2_tag.valid && s2_tag.in_range && (s2_tag.chan == in_chan)) ||
                   (s3_tag.valid && s3_tag.in_range && (s3_tag.chan == in_chan)));

  assign occupancy = OCC_W'(fifo_count) + OCC_W'(s1_tag.valid) + OCC_W'(s2_tag.valid) +
                     OCC_W'(s3_tag.valid);

  assign s_tready = (occupancy < OCC_W'(FIFO_DEPTH)) && !hazard;
  assign accept   = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // History store: read on the accept edge, written back from the last stage.
  // The interlock above keeps a read and a write of the same entry apart.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    rd_data  <= hist_mem[in_addr];
    rd_valid <= hist_valid[in_addr];
    if (wb_en) begin
      hist_mem[s3_addr] <= '{y2: s3_y1, y1: y_sat, x2: s3_x1, x1: s3_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else if (wb_en) begin
      hist_valid[s3_addr] <= 1'b1;
    end
  end

  // An entry never written since reset reads as an all-zero history.
  assign s1_hist = rd_valid ? rd_data : '0;

  // ---------------------------------------------------------------------------
  // Pipeline tags and the values needed for the history update.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
      s2_tag <= '0;
      s3_tag <= '0;
    end else begin
      s1_tag <= '{valid: accept, in_range: in_range, chan: in_chan};
      s2_tag <= s1_tag;
      s3_tag <= s2_tag;
    end
  end

  always_ff @(posedge clk) begin
    s1_x  <= in_sample;
    s2_x  <= s1_x;
    s3_x  <= s2_x;
    s2_x1 <= s1_hist.x1;
    s3_x1 <= s2_x1;
    s2_y1 <= s1_hist.y1;
    s3_y1 <= s2_y1;
  end

  mbq_mac u_mac (
    .clk   (clk),
    .x     (s1_x),
    .hist  (s1_hist),
    .coeff (coeff),
    .y     (y_sat)
  );

  assign s3_addr = CHAN_AW'(s3_tag.chan);
  assign wb_en   = s3_tag.valid && s3_tag.in_range;

  // A channel number past the last channel yields zero and leaves all history alone.
  assign res.chan  = s3_tag.chan;
  assign res.value = s3_tag.in_range ? y_sat : '0;

  // ---------------------------------------------------------------------------
  // Result queue. Admission is counted against its depth, so a push always fits.
  // ---------------------------------------------------------------------------
  assign push     = s3_tag.valid;
  assign m_tvalid = (fifo_count != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = M_TDATA_W'(fifo_mem[rd_ptr]);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fifo_count <= fifo_count + 1'b1;
      end else if (pop && !push) begin
        fifo_count <= fifo_count - 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  // No two words of the same channel are ever in flight together.
  a_no_same_chan: assert property (@(posedge clk) disable iff (rst)
    (s1_tag.valid && s1_tag.in_range && s2_tag.valid && s2_tag.in_range)
      |-> (s1_tag.chan != s2_tag.chan))
    else $error("two words of one channel in adjacent stages");

  a_no_same_chan_far: assert property (@(posedge clk) disable iff (rst)
    (s1_tag.valid && s1_tag.in_range && s3_tag.valid && s3_tag.in_range)
      |-> (s1_tag.chan != s3_tag.chan))
    else $error("two words of one channel two stages apart");

  // Words in the pipeline plus queued results never exceed the queue depth.
  a_credit: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(FIFO_DEPTH))
    else $error("result queue overcommitted");

  // A history write-back marks its channel as holding data from then on.
  a_hist_mark: assert property (@(posedge clk) disable iff (rst)
    wb_en |=> hist_valid[$past(s3_addr)])
    else $error("history entry not marked after write-back");

endmodule

/* tb/mbq_checker.sv */
// Checker for the multichannel biquad filter: predicts every output word and compares it.
module mbq_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [mbq_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [mbq_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                          cfg_wen,
  input  logic [mbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbq_pkg::COEFF_W-1:0]   cfg_wdata,
  output int                            fail_count,
  output int                            pending
);
  import mbq_pkg::*;

  localparam longint Y_MAX = 64'sd2147483647;
  localparam longint Y_MIN = -64'sd2147483648;

  coeff_t                     coef;
  logic signed [SAMPLE_W-1:0] x_prev  [NUM_CHANNELS];
  logic signed [SAMPLE_W-1:0] x_prev2 [NUM_CHANNELS];
  logic signed [OUT_W-1:0]    y_prev  [NUM_CHANNELS];
  logic signed [OUT_W-1:0]    y_prev2 [NUM_CHANNELS];
  result_t                    expected_words [$];

  // Filters one sample of one channel and shifts that channel's history.
  function automatic logic signed [OUT_W-1:0] biquad_output(
    input logic [CHAN_W-1:0]        ch,
    input logic signed [SAMPLE_W-1:0] x
  );
    longint acc;
    longint y;
    if (ch >= NUM_CHANNELS) return '0;
    // Feedforward products are exact in Q.30; feedback products are Q.46 floored to Q.30.
    acc = longint'(coef.b0) * longint'(x)
        + longint'(coef.b1) * longint'(x_prev[ch])
        + longint'(coef.b2) * longint'(x_prev2[ch])
        - ((longint'(coef.a1) * longint'(y_prev[ch])) >>> FB_SHIFT)
        - ((longint'(coef.a2) * longint'(y_prev2[ch])) >>> FB_SHIFT);
    y = (acc + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (y > Y_MAX) y = Y_MAX;
    else if (y < Y_MIN) y = Y_MIN;
    x_prev2[ch] = x_prev[ch];
    x_prev[ch]  = x;
    y_prev2[ch] = y_prev[ch];
    y_prev[ch]  = OUT_W'(y);
    return OUT_W'(y);
  endfunction

  always @(posedge clk) begin
    int      n_bad;
    result_t got;
    result_t want;
    if (rst) begin
      coef = '{b0: RST_FEED_COEFF_ZERO, b1: RST_FEED_COEFF_ONE, b2: RST_FEED_COEFF_TWO,
               a1: RST_BACK_COEFF_ONE, a2: RST_BACK_COEFF_TWO};
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        x_prev[i]  = '0;
        x_prev2[i] = '0;
        y_prev[i]  = '0;
        y_prev2[i] = '0;
      end
      expected_words.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      n_bad = 0;
      if (cfg_wen) begin
        case (cfg_index)
          REG_FEED_COEFF_ZERO: coef.b0 = cfg_wdata;
          REG_FEED_COEFF_ONE:  coef.b1 = cfg_wdata;
          REG_FEED_COEFF_TWO:  coef.b2 = cfg_wdata;
          REG_BACK_COEFF_ONE:  coef.a1 = cfg_wdata;
          REG_BACK_COEFF_TWO:  coef.a2 = cfg_wdata;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[$bits(result_t)-1:0]);
        if (expected_words.size() == 0) begin
          $error("unexpected output word: chan_out %0d, filtered_out %0d", got.chan, got.value);
          n_bad++;
        end else begin
          want = expected_words.pop_front();
          if (got.chan !== want.chan) begin
            $error("chan_out: expected %0d, got %0d", want.chan, got.chan);
            n_bad++;
          end
          if (got.value !== want.value) begin
            $error("filtered_out: expected %0d, got %0d", want.value, got.value);
            n_bad++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want.chan  = s_tdata[CHAN_W-1:0];
        want.value = biquad_output(want.chan, s_tdata[CHAN_W +: SAMPLE_W]);
        expected_words.push_back(want);
      end
      fail_count <= fail_count + n_bad;
      pending    <= expected_words.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Top of the testbench for the multichannel biquad filter: stimulus, back-pressure and verdict.
module tb_top;
  import mbq_pkg::*;

  // The run is split into phases. Each phase, with the filter idle, first programmes a coefficient
  // set or keeps the current one, then picks an idling pattern and streams words through it.
  localparam int NUM_PHASES       = 10;
  localparam int RANDOM_PER_PHASE = 175;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = 8;

  typedef enum {
    COEF_RESET, COEF_DEFAULT, COEF_MAX, COEF_MIN, COEF_UNITY, COEF_RANDOM, COEF_MIXED,
    COEF_IGNORED
  } coef_plan_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // Register indexes in the order in which the coefficients are held.
  localparam logic [CFG_IDX_W-1:0] COEF_REGS [5] = '{
    REG_FEED_COEFF_ZERO, REG_FEED_COEFF_ONE, REG_FEED_COEFF_TWO,
    REG_BACK_COEFF_ONE, REG_BACK_COEFF_TWO
  };
  localparam logic signed [COEFF_W-1:0] COEF_RESETS [5] = '{
    RST_FEED_COEFF_ZERO, RST_FEED_COEFF_ONE, RST_FEED_COEFF_TWO,
    RST_BACK_COEFF_ONE, RST_BACK_COEFF_TWO
  };
  localparam logic signed [COEFF_W-1:0] COEF_UNITY_GAIN = 32'sh4000_0000;  // 1.0 in Q2.30

  // Saturating coefficient sets come early so that the history carries extreme values
  // into the later phases; the ignored-index phase leaves the previous set in place.
  localparam coef_plan_t PHASE_PLAN [NUM_PHASES] = '{
    COEF_RESET, COEF_MAX, COEF_RANDOM, COEF_UNITY, COEF_MIXED,
    COEF_MIN, COEF_RANDOM, COEF_IGNORED, COEF_DEFAULT, COEF_RANDOM
  };

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;   // [2:0] chan, [18:3] sample_in, zeros above
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;          // [2:0] chan_out, [34:3] filtered_out, zeros above
  logic                 cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEFF_W-1:0]   cfg_wdata = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int gap_pct     = 0;   // chance in a hundred that the sender idles in a given cycle
  int stall_pct   = 0;   // chance in a hundred that the receiver holds tready low

  multichannel_biquad_lowpass dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mbq_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver decides afresh each cycle whether it will take a word.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a hung handshake or a word that never comes out ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Offers one word and returns at the edge where it is taken. The idle cycles in front
  // of it are drawn one by one, so the gaps land on every phase of the pipeline.
  task automatic send_word(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'({smp, ch});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Leaves cfg_wen high so that back-to-back writes do not toggle it within one step;
  // the caller lowers it after the last write of a series.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Returns once every predicted word has been seen on the output. Every input word
  // yields exactly one output word, so nothing is left inside the filter by then.
  task automatic wait_until_idle;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] smp;
    chan = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_until_idle();

      case (PHASE_PLAN[phase])
        COEF_DEFAULT: for (int r = 0; r < 5; r++) write_reg(COEF_REGS[r], COEF_RESETS[r]);
        COEF_MAX:     for (int r = 0; r < 5; r++) write_reg(COEF_REGS[r], 32'h7FFF_FFFF);
        COEF_MIN:     for (int r = 0; r < 5; r++) write_reg(COEF_REGS[r], 32'h8000_0000);
        COEF_RANDOM:  for (int r = 0; r < 5; r++) write_reg(COEF_REGS[r], $urandom);
        COEF_UNITY: begin
          // Plain pass-through: the output is the sample moved up to Q16.16.
          write_reg(REG_FEED_COEFF_ZERO, COEF_UNITY_GAIN);
          for (int r = 1; r < 5; r++) write_reg(COEF_REGS[r], '0);
        end
        COEF_MIXED: begin
          // Modest random feedforward gains in front of the stable default poles.
          for (int r = 0; r < 3; r++) write_reg(COEF_REGS[r], $signed($urandom) >>> 8);
          write_reg(REG_BACK_COEFF_ONE, RST_BACK_COEFF_ONE);
          write_reg(REG_BACK_COEFF_TWO, RST_BACK_COEFF_TWO);
        end
        COEF_IGNORED: begin
          // Writes to indexes beyond the last register must leave every coefficient alone.
          for (int r = int'(REG_BACK_COEFF_TWO) + 1; r < (1 << CFG_IDX_W); r++) begin
            write_reg(CFG_IDX_W'(r), $urandom);
          end
        end
        default: ;
      endcase
      cfg_wen <= 1'b0;

      case (idle_mode_t'(phase % 4))
        IDLE_NONE:     begin gap_pct = 0;  stall_pct <= 0;  end
        IDLE_SENDER:   begin gap_pct = 81; stall_pct <= 0;  end
        IDLE_RECEIVER: begin gap_pct = 0;  stall_pct <= 81; end
        default:       begin gap_pct = 21; stall_pct <= 21; end
      endcase

      // Directed words: full-scale steps of both signs on every channel with the reset
      // filter, then small values around zero on the highest channel.
      if (PHASE_PLAN[phase] == COEF_RESET) begin
        for (int c = 0; c < NUM_CHANNELS; c++) send_word(CHAN_W'(c), 16'h7FFF);
        for (int c = 0; c < NUM_CHANNELS; c++) send_word(CHAN_W'(c), 16'h8000);
        send_word(CHAN_W'(NUM_CHANNELS - 1), 16'h0000);
        send_word(CHAN_W'(NUM_CHANNELS - 1), 16'hFFFF);
        send_word(CHAN_W'(NUM_CHANNELS - 1), 16'h0001);
      end

      // With every coefficient at its maximum, full-scale samples drive the output into
      // saturation at both ends, and the clipped value feeds back through the history.
      if (PHASE_PLAN[phase] == COEF_MAX) begin
        send_word('0, 16'h7FFF);
        send_word('0, 16'h7FFF);
        send_word('0, 16'h8000);
        send_word('0, 16'h8000);
        send_word('0, 16'h8000);
      end

      // Random words. Roughly a third reuse the previous channel, which both builds up a
      // channel's history quickly and exercises the same-channel hold-off in the pipeline.
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(99) >= 30) chan = CHAN_W'($urandom_range(NUM_CHANNELS - 1));
        case ($urandom_range(7))
          0:       smp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
          1:       smp = SAMPLE_W'(int'($urandom_range(32)) - 16);
          default: smp = SAMPLE_W'($urandom);
        endcase
        send_word(chan, smp);
      end
    end

    wait_until_idle();
    // The drain wait catches any stray word that turns up after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* multichannel_biquad_lowpass.f */
hdl/mbq_pkg.sv
hdl/mbq_mac.sv
hdl/multichannel_biquad_lowpass.sv
tb/mbq_checker.sv
tb/tb_top.sv
